// ----- hw/rtl/haversine_distance_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the haversine distance block
// Concurrent checks on i_clk that are switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_ASSERT_SVH
`define HAVERSINE_DISTANCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("haversine distance check failed");

// The consequent must hold in the cycle after the antecedent.
`define HD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("haversine distance check failed");

`endif

// ----- hw/rtl/hd_pkg.sv -----
// ----------------------------------------------------------------------------
// hd_pkg
// Types, constants and the arctangent table of the haversine distance block.
// ----------------------------------------------------------------------------
package hd_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int ROOT_STEPS    = 31;

    typedef logic        [33:0] t_bam;
    typedef logic signed [31:0] t_trig;
    typedef logic        [60:0] t_q60;
    typedef logic        [30:0] t_q30u;

    localparam logic        [30:0] DEG7_TO_BAM = 31'd1281023894;
    localparam logic        [30:0] PI8_Q32     = 31'd1686629713;
    localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
    localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [32:0] INV_GAIN    = 33'sd652032874;
    localparam logic        [30:0] DIST_SCALE  = 31'd1274200000;
    localparam t_q60               ONE_Q60     = 61'h1000_0000_0000_0000;
    localparam logic        [30:0] MAX_DIST_CM = 31'd2001509000;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic signed [32:0] atan_q30(input int i);
        logic signed [32:0] v;
        case (i)
            0:  v = 33'sd843314856;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043836;
            3:  v = 33'sd133525158;
            4:  v = 33'sd67021686;
            5:  v = 33'sd33543515;
            6:  v = 33'sd16775850;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194282;
            9:  v = 33'sd2097149;
            10: v = 33'sd1048575;
            default: begin
                if (i <= 30) v = 33'sd1 <<< (30 - i);
                else v = '0;
            end
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/hd_pt_if.sv -----
// ----------------------------------------------------------------------------
// hd_pt_if
// Channel that carries one pair of geographic points per item.
// ----------------------------------------------------------------------------
interface hd_pt_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] first_latitude;
    logic signed [31:0] first_longitude;
    logic signed [30:0] second_latitude;
    logic signed [31:0] second_longitude;

    modport source(output valid, output first_latitude, output first_longitude,
                   output second_latitude, output second_longitude, input ready);
    modport sink(input valid, input first_latitude, input first_longitude,
                 input second_latitude, input second_longitude, output ready);
endinterface

// ----- hw/rtl/hd_dist_if.sv -----
// ----------------------------------------------------------------------------
// hd_dist_if
// Channel that carries one distance in centimeters per item.
// ----------------------------------------------------------------------------
interface hd_dist_if;
    logic        valid;
    logic        ready;
    logic [30:0] distance_cm;

    modport source(output valid, output distance_cm, input ready);
    modport sink(input valid, input distance_cm, output ready);
endinterface

// ----- hw/rtl/hd_rot.sv -----
// ----------------------------------------------------------------------------
// hd_rot
// Pipelined rotation CORDIC: sine and cosine of a 34-bit binary angle.
// ----------------------------------------------------------------------------
module hd_rot (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  hd_pkg::t_bam  i_bam,
    output logic          o_valid,
    output hd_pkg::t_trig o_sin,
    output hd_pkg::t_trig o_cos
);
    localparam int N = hd_pkg::CORDIC_N;
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic signed [32:0] r_x [0:N];
    logic signed [32:0] r_y [0:N];
    logic signed [32:0] r_z [0:N];
    logic        [1:0]  r_q [0:N];
    logic        [N:0]  r_v;
    logic               r_ov;
    hd_pkg::t_trig      r_sin, r_cos;

    logic        [63:0] w_prod;
    logic signed [32:0] w_xc, w_yc;

    // Angle within the quadrant scaled to Q30 radians.
    assign w_prod = 64'(i_bam[31:0]) * 64'(hd_pkg::PI8_Q32) + 64'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= hd_pkg::INV_GAIN;
            r_y[0] <= '0;
            r_z[0] <= $signed({1'b0, w_prod[63:32]});
            r_q[0] <= i_bam[33:32];
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [32:0] w_dx, w_dy;
        assign w_dx = r_y[k] >>> k;
        assign w_dy = r_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][32]) begin
                    r_x[k+1] <= r_x[k] - w_dx;
                    r_y[k+1] <= r_y[k] + w_dy;
                    r_z[k+1] <= r_z[k] - hd_pkg::atan_q30(k);
                end else begin
                    r_x[k+1] <= r_x[k] + w_dx;
                    r_y[k+1] <= r_y[k] - w_dy;
                    r_z[k+1] <= r_z[k] + hd_pkg::atan_q30(k);
                end
                r_q[k+1] <= r_q[k];
            end
        end
    end

    always_comb begin
        if (r_x[N] < 0) w_xc = '0;
        else if (r_x[N] > hd_pkg::ONE_Q30) w_xc = hd_pkg::ONE_Q30;
        else w_xc = r_x[N];
        if (r_y[N] < 0) w_yc = '0;
        else if (r_y[N] > hd_pkg::ONE_Q30) w_yc = hd_pkg::ONE_Q30;
        else w_yc = r_y[N];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[N];
        end
    end

    // Quadrant symmetry.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[N])
                QUAD_0: begin
                    r_sin <= 32'(w_yc);
                    r_cos <= 32'(w_xc);
                end
                QUAD_1: begin
                    r_sin <= 32'(w_xc);
                    r_cos <= 32'(-w_yc);
                end
                QUAD_2: begin
                    r_sin <= 32'(-w_yc);
                    r_cos <= 32'(-w_xc);
                end
                default: begin
                    r_sin <= 32'(-w_xc);
                    r_cos <= 32'(w_yc);
                end
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;
endmodule

// ----- hw/rtl/hd_isqrt.sv -----
// ----------------------------------------------------------------------------
// hd_isqrt
// Pipelined digit-by-digit floor square root of a Q60 value, one bit a stage.
// ----------------------------------------------------------------------------
module hd_isqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  hd_pkg::t_q60  i_n,
    output logic          o_valid,
    output hd_pkg::t_q30u o_root
);
    localparam int S = hd_pkg::ROOT_STEPS;

    logic [60:0] r_n   [0:S];
    logic [60:0] r_res [0:S];
    logic [S:0]  r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= i_n;
            r_res[0] <= '0;
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_step
        logic [61:0] w_bit, w_sum;
        assign w_bit = 62'd1 << (2 * (S - 1 - k));
        assign w_sum = {1'b0, r_res[k]} + w_bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, r_n[k]} >= w_sum) begin
                    r_n[k+1]   <= r_n[k] - w_sum[60:0];
                    r_res[k+1] <= (r_res[k] >> 1) + w_bit[60:0];
                end else begin
                    r_n[k+1]   <= r_n[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[S];
    assign o_root  = r_res[S][30:0];
endmodule

// ----- hw/rtl/hd_vec.sv -----
// ----------------------------------------------------------------------------
// hd_vec
// Pipelined vectoring CORDIC: first-quadrant arctangent of y over x in Q30.
// ----------------------------------------------------------------------------
module hd_vec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  hd_pkg::t_q30u i_y,
    input  hd_pkg::t_q30u i_x,
    output logic          o_valid,
    output hd_pkg::t_q30u o_angle
);
    localparam int N = hd_pkg::CORDIC_N;

    logic signed [34:0] r_x [0:N];
    logic signed [34:0] r_y [0:N];
    logic signed [32:0] r_z [0:N];
    logic        [N:0]  r_zero;
    logic        [N:0]  r_v;
    logic               r_ov;
    hd_pkg::t_q30u      r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= $signed({4'b0, i_x});
            r_y[0]    <= $signed({4'b0, i_y});
            r_z[0]    <= '0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [34:0] w_dx, w_dy;
        assign w_dx = r_y[k] >>> k;
        assign w_dy = r_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + w_dx;
                    r_y[k+1] <= r_y[k] - w_dy;
                    r_z[k+1] <= r_z[k] + hd_pkg::atan_q30(k);
                end else begin
                    r_x[k+1] <= r_x[k] - w_dx;
                    r_y[k+1] <= r_y[k] + w_dy;
                    r_z[k+1] <= r_z[k] - hd_pkg::atan_q30(k);
                end
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[N];
        end
    end

    // A zero vector has no angle and reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[N] || r_z[N] < 0) r_angle <= '0;
            else if (r_z[N] > hd_pkg::HALF_PI_Q30) r_angle <= hd_pkg::HALF_PI_Q30[30:0];
            else r_angle <= r_z[N][30:0];
        end
    end

    assign o_valid = r_ov;
    assign o_angle = r_angle;
endmodule

// ----- hw/rtl/haversine_distance.sv -----
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two points by the haversine formula.
// ----------------------------------------------------------------------------
// Usage:
// The input channel i_pts carries one item per pair of points: two latitudes
// and two longitudes in signed units of 1e-7 degree. The output channel
// o_dist returns one item per input item, the distance in centimeters on a
// sphere of radius 6371 km, in the same order as the inputs arrived.
// Both channels use a valid/ready handshake; an item moves at a clock edge
// where both are high.
// The block is a single pipeline that accepts one item every cycle while the
// output is not held back. An item runs through the four parallel rotation
// CORDICs, the two 31-step square root units and the vectoring CORDIC, each
// spending one register stage per iteration.
// When the receiver holds ready low while a result waits, the whole pipeline
// freezes and i_pts.ready drops; nothing is lost or repeated, and a new item
// is taken as soon as the output register frees up.
// A synchronous reset (i_rst_n low) clears all valid bits. The block keeps no
// other state, so it is ready for items in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "haversine_distance_assert.svh"

module haversine_distance (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hd_pt_if.sink      i_pts,
    hd_dist_if.source  o_dist
);
    // Valid bit of the output register.
    logic r_ov;

    // Global advance: every stage moves when the output register is free.
    logic w_en;
    assign w_en        = !r_ov || o_dist.ready;
    assign i_pts.ready = w_en;

    // Stage A: magnitude times the degree-to-binary-angle factor.
    // Order of the four angles: first lat, first lon, second lat, second lon.
    logic signed [31:0] w_coord [0:3];
    logic        [31:0] w_mag   [0:3];
    logic        [62:0] r_pm    [0:3];
    logic        [3:0]  r_nega;
    logic               r_va;

    assign w_coord[0] = 32'(i_pts.first_latitude);
    assign w_coord[1] = i_pts.first_longitude;
    assign w_coord[2] = 32'(i_pts.second_latitude);
    assign w_coord[3] = i_pts.second_longitude;

    // Stage B: rounding and negation to a binary angle modulo one turn.
    hd_pkg::t_bam r_bam [0:3];
    logic         r_vb;

    // Stage D: half differences and the two raw latitudes.
    hd_pkg::t_bam w_dlat, w_dlon;
    hd_pkg::t_bam r_ang [0:3];
    logic         r_vd;

    for (genvar k = 0; k < 4; k++) begin : g_conv
        logic [63:0] w_rnd;
        logic [33:0] w_b;

        assign w_mag[k] = w_coord[k][31] ? 32'(-w_coord[k]) : 32'(w_coord[k]);
        assign w_rnd    = 64'(r_pm[k]) + 64'h0800_0000;
        assign w_b      = w_rnd[61:28];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pm[k]   <= 63'(w_mag[k]) * 63'(hd_pkg::DEG7_TO_BAM);
                r_nega[k] <= w_coord[k][31];
                r_bam[k]  <= r_nega[k] ? 34'(-w_b) : w_b;
            end
        end
    end

    assign w_dlat = r_bam[2] - r_bam[0];
    assign w_dlon = r_bam[3] - r_bam[1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang[0] <= {1'b0, w_dlat[33:1]};
            r_ang[1] <= {1'b0, w_dlon[33:1]};
            r_ang[2] <= r_bam[0];
            r_ang[3] <= r_bam[2];
        end
    end

    // Sine and cosine of the four angles.
    logic          [3:0] w_rv;
    hd_pkg::t_trig       w_sin [0:3];
    hd_pkg::t_trig       w_cos [0:3];

    for (genvar k = 0; k < 4; k++) begin : g_rot
        hd_rot u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_vd),
            .i_bam   (r_ang[k]),
            .o_valid (w_rv[k]),
            .o_sin   (w_sin[k]),
            .o_cos   (w_cos[k])
        );
    end

    // Haversine term: a = sh^2 + ((c1*c2 >> 30) * sl >> 30) * sl, Q60.
    logic signed [63:0] r_hh1, r_cc, r_hh2, r_ts, r_hh3, r_us;
    hd_pkg::t_trig      r_sl1, r_sl2;
    hd_pkg::t_trig      w_t, w_u;
    logic signed [63:0] w_a;
    hd_pkg::t_q60       w_ac;
    hd_pkg::t_q60       r_a, r_b;
    logic               r_v1, r_v2, r_v3, r_v4;

    assign w_t = 32'(r_cc >>> 30);
    assign w_u = 32'(r_ts >>> 30);
    assign w_a = r_hh3 + r_us;

    // Clamp against rounding error so that a stays within [0, 1].
    always_comb begin
        if (w_a < 0) w_ac = '0;
        else if (w_a > $signed({3'b0, hd_pkg::ONE_Q60})) w_ac = hd_pkg::ONE_Q60;
        else w_ac = w_a[60:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hh1 <= 64'(w_sin[0]) * 64'(w_sin[0]);
            r_cc  <= 64'(w_cos[2]) * 64'(w_cos[3]);
            r_sl1 <= w_sin[1];
            r_ts  <= 64'(w_t) * 64'(r_sl1);
            r_hh2 <= r_hh1;
            r_sl2 <= r_sl1;
            r_us  <= 64'(w_u) * 64'(r_sl2);
            r_hh3 <= r_hh2;
            r_a   <= w_ac;
            r_b   <= hd_pkg::ONE_Q60 - w_ac;
        end
    end

    // Square roots of a and 1 - a.
    logic          [1:0] w_qv;
    hd_pkg::t_q30u       w_ra, w_rb;

    hd_isqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_n     (r_a),
        .o_valid (w_qv[0]),
        .o_root  (w_ra)
    );

    hd_isqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_n     (r_b),
        .o_valid (w_qv[1]),
        .o_root  (w_rb)
    );

    // Central half angle by the arctangent of the two roots.
    logic          w_vv;
    hd_pkg::t_q30u w_ang;

    hd_vec u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (&w_qv),
        .i_y     (w_ra),
        .i_x     (w_rb),
        .o_valid (w_vv),
        .o_angle (w_ang)
    );

    // Scale by twice the radius, then round to whole centimeters.
    logic [61:0] r_dp;
    logic [61:0] w_dsum;
    logic        r_vm;
    logic [30:0] r_od;

    assign w_dsum = r_dp + 62'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dp <= 62'(w_ang) * 62'(hd_pkg::DIST_SCALE);
            r_od <= w_dsum[60:30];
        end
    end

    // Valid bits of the stages owned by this level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vd <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vm <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_va <= i_pts.valid;
            r_vb <= r_va;
            r_vd <= r_vb;
            r_v1 <= &w_rv;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vm <= w_vv;
            r_ov <= r_vm;
        end
    end

    assign o_dist.valid       = r_ov;
    assign o_dist.distance_cm = r_od;

    // The input side only stalls behind a result that is held back.
    `HD_ASSERT_IMPL(a_stall_cause, !i_pts.ready, o_dist.valid && !o_dist.ready)
    // The distance never exceeds half the circumference.
    `HD_ASSERT_IMPL(a_dist_range, o_dist.valid, o_dist.distance_cm <= hd_pkg::MAX_DIST_CM)
    // The clamped haversine term lies within [0, 1].
    `HD_ASSERT_IMPL(a_hav_range, r_v4, r_a <= hd_pkg::ONE_Q60)
    // A delivered result with nothing behind it leaves the output empty.
    `HD_ASSERT_NEXT(a_drain, o_dist.valid && o_dist.ready && !r_vm, !o_dist.valid)
endmodule

// ----- dv/haversine_distance_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// haversine_distance_tb
// Self-checking bench for the great-circle distance pipeline. A bit-exact
// fixed-point model of the haversine datapath (binary angles, rotation and
// vectoring CORDICs, digit-by-digit roots) predicts each distance. Pairs of
// points are driven with random gaps, results are drained with random stalls,
// and every result is compared in order against the predicted distance.
// ----------------------------------------------------------------------------
module haversine_distance_tb;

    localparam int NUM_ITEMS   = 1600;
    localparam int NUM_CORNERS = 22;
    // Pipeline depth of the block, with some margin.
    localparam int DRAIN_CYCLES = 2 * hd_pkg::CORDIC_STAGES + 45 + 100;

    typedef struct packed {
        logic signed [30:0] lat1;
        logic signed [31:0] lon1;
        logic signed [30:0] lat2;
        logic signed [31:0] lon2;
    } t_point_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hd_pt_if   pts_ch();
    hd_dist_if dist_ch();

    haversine_distance dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pts   (pts_ch.sink),
        .o_dist  (dist_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the distance of every accepted pair of points and
    // keeps the predictions in arrival order, since the block never reorders.
    // ------------------------------------------------------------------------
    class distance_scoreboard;
        logic [30:0] pending_cm[$];
        int          num_errors;

        function new();
            num_errors = 0;
        endfunction

        // Arctangent of 2^-i in Q30 radians, the table the block iterates over.
        function longint arctan_step(int i);
            longint head[11] = '{843314856, 497837829, 263043836, 133525158,
                                 67021686, 33543515, 16775850, 8388437,
                                 4194282, 2097149, 1048575};
            if (i < 11) return head[i];
            if (i <= 30) return longint'(1) << (30 - i);
            return 0;
        endfunction

        // Angle in 1e-7 degree to a binary angle of 2^34 steps per turn.
        function bit [33:0] deg7_to_binary_angle(longint deg7);
            bit [63:0] mag;
            bit [63:0] b;
            mag = (deg7 < 0) ? -deg7 : deg7;
            b = (mag * 64'd1281023894 + (64'd1 << 27)) >> 28;
            if (deg7 < 0) b = -b;
            return b[33:0];
        endfunction

        // Rotation CORDIC over the first quadrant, then quadrant symmetry.
        function void rotate(bit [33:0] ang, output longint sn, output longint cs);
            bit [63:0] r;
            longint z, x, y, dx, dy;
            r = {32'd0, ang[31:0]};
            z = longint'((r * 64'd1686629713 + (64'd1 << 31)) >> 32);
            x = 652032874;
            y = 0;
            for (int i = 0; i < hd_pkg::CORDIC_N; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= arctan_step(i);
                end else begin
                    x += dx; y -= dy; z += arctan_step(i);
                end
            end
            if (x < 0) x = 0; else if (x > 1073741824) x = 1073741824;
            if (y < 0) y = 0; else if (y > 1073741824) y = 1073741824;
            case (ang[33:32])
                2'd0: begin sn = y;  cs = x;  end
                2'd1: begin sn = x;  cs = -y; end
                2'd2: begin sn = -y; cs = -x; end
                default: begin sn = -x; cs = y; end
            endcase
        endfunction

        // Floor square root of a Q60 value, giving Q30.
        function bit [63:0] isqrt_q60(bit [63:0] n);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 60;
            for (int i = 0; i < 31; i++) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Vectoring CORDIC; the angle of (x, y) in Q30 radians.
        function longint vector_angle(longint y, longint x);
            longint z, dx, dy;
            z = 0;
            if (x == 0 && y == 0) return 0;
            for (int i = 0; i < hd_pkg::CORDIC_N; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += arctan_step(i);
                end else begin
                    x -= dx; y += dy; z -= arctan_step(i);
                end
            end
            if (z < 0) z = 0; else if (z > 1686629713) z = 1686629713;
            return z;
        endfunction

        function logic [30:0] predict_distance(t_point_pair p);
            bit [33:0] lat1, lon1, lat2, lon2;
            longint sin_dlat, sin_dlon, cos1, cos2, unused;
            longint t, u, hav, ang;
            bit [63:0] ra, rb, scaled_cm;
            lat1 = deg7_to_binary_angle(longint'(p.lat1));
            lon1 = deg7_to_binary_angle(longint'(p.lon1));
            lat2 = deg7_to_binary_angle(longint'(p.lat2));
            lon2 = deg7_to_binary_angle(longint'(p.lon2));
            // Half differences are taken on the wrapped 34-bit angle.
            rotate(34'(lat2 - lat1) >> 1, sin_dlat, unused);
            rotate(34'(lon2 - lon1) >> 1, sin_dlon, unused);
            rotate(lat1, unused, cos1);
            rotate(lat2, unused, cos2);
            t = (cos1 * cos2) >>> 30;
            u = (t * sin_dlon) >>> 30;
            hav = sin_dlat * sin_dlat + u * sin_dlon;
            // Rounding can push the haversine term just outside [0, 1].
            if (hav < 0) hav = 0;
            else if (hav > (longint'(1) << 60)) hav = longint'(1) << 60;
            ra = isqrt_q60(hav);
            rb = isqrt_q60((64'd1 << 60) - hav);
            ang = vector_angle(longint'(ra), longint'(rb));
            scaled_cm = (64'd1274200000 * ang + (64'd1 << 29)) >> 30;
            return scaled_cm[30:0];
        endfunction

        function void note_pair(t_point_pair p);
            pending_cm.push_back(predict_distance(p));
        endfunction

        task report_mismatch(string what, logic [30:0] got, logic [30:0] want);
            $display("%0t: distance_cm %s: got %0d, expected %0d", $time, what, got, want);
            num_errors++;
        endtask

        task check_distance(logic [30:0] got);
            logic [30:0] want;
            if (pending_cm.size() == 0) begin
                report_mismatch("without a pending pair", got, 31'd0);
            end else begin
                want = pending_cm.pop_front();
                if (got !== want) report_mismatch("mismatch", got, want);
            end
        endtask
    endclass

    distance_scoreboard scoreboard = new();

    // ------------------------------------------------------------------------
    // Stimulus. The first items are corner cases: zero, the poles, the date
    // line, antipodes, latitudes past 90 degrees and longitudes past 180
    // degrees that wrap, and the most negative and positive raw codes. The
    // rest is random, mostly within the documented ranges, some with nearby
    // points so that tiny distances are covered, and some raw full-width codes.
    // ------------------------------------------------------------------------
    function automatic t_point_pair make_pair(int idx);
        t_point_pair p;
        int sel;
        t_point_pair corners[NUM_CORNERS] = '{
            '{31'sd0, 32'sd0, 31'sd0, 32'sd0},
            '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0},
            '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000},
            '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000},
            '{31'sd0, 32'sd1799999999, 31'sd0, -32'sd1799999999},
            '{31'sd450000000, 32'sd900000000, -31'sd450000000, -32'sd900000000},
            '{31'sd900000000, 32'sd1234567, 31'sd900000000, -32'sd7654321},
            '{-31'sd900000000, 32'sd0, -31'sd899999999, 32'sd1800000000},
            '{31'sd0, 32'sd0, 31'sd1, 32'sd0},
            '{31'sd0, 32'sd0, 31'sd0, 32'sd1},
            '{31'sd515000000, -32'sd1270000, 31'sd407000000, -32'sd740000000},
            '{31'sd1073741823, 32'sd0, 31'sd0, 32'sd0},
            '{-31'sd1073741824, 32'sd0, 31'sd1073741823, 32'sd0},
            '{31'sd0, 32'sd2147483647, 31'sd0, -32'sd2147483648},
            '{31'sd0, -32'sd2147483648, 31'sd0, 32'sd0},
            '{31'sd0, 32'sd2000000000, 31'sd0, -32'sd1600000000},
            '{31'sd950000000, 32'sd100000000, 31'sd0, 32'sd0},
            '{-31'sd1073741824, -32'sd2147483648, -31'sd1073741824, 32'sd2147483647},
            '{31'sd1073741823, 32'sd2147483647, -31'sd1073741824, -32'sd2147483648},
            '{31'sd123456789, 32'sd987654321, -31'sd123456789, -32'sd1192345679},
            '{31'sd899999999, 32'sd0, -31'sd899999999, 32'sd1799999999},
            '{-31'sd333333333, 32'sd1777777777, 31'sd333333333, -32'sd1777777777}
        };
        if (idx < NUM_CORNERS) return corners[idx];
        sel = $urandom_range(99);
        p.lat1 = 31'($signed($urandom_range(1800000000)) - 900000000);
        p.lon1 = 32'(longint'($urandom_range(3600000000)) - 64'sd1800000000);
        if (sel < 65) begin
            p.lat2 = 31'($signed($urandom_range(1800000000)) - 900000000);
            p.lon2 = 32'(longint'($urandom_range(3600000000)) - 64'sd1800000000);
        end else if (sel < 85) begin
            p.lat2 = p.lat1 + 31'($signed($urandom_range(2000)) - 1000);
            p.lon2 = p.lon1 + 32'($signed($urandom_range(2000)) - 1000);
        end else begin
            p.lat1 = 31'($urandom);
            p.lon1 = $urandom;
            p.lat2 = 31'($urandom);
            p.lon2 = $urandom;
        end
        return p;
    endfunction

    // Idle at random with a chance of 6 in 100, except in a quiet stretch of cycles.
    function automatic bit take_break(int cycle);
        if (cycle >= 700 && cycle < 1300) return 1'b0;
        return $urandom_range(99) < 6;
    endfunction

    int num_sent = 0;
    int send_cycle = 0;

    task automatic drive_points();
        t_point_pair p;
        int next_idx;
        next_idx = 0;
        while (num_sent < NUM_ITEMS) begin
            @(posedge i_clk);
            send_cycle++;
            if (pts_ch.valid && pts_ch.ready) begin
                scoreboard.note_pair({pts_ch.first_latitude, pts_ch.first_longitude,
                                      pts_ch.second_latitude, pts_ch.second_longitude});
                num_sent++;
            end
            if (!pts_ch.valid || pts_ch.ready) begin
                if (next_idx < NUM_ITEMS && !take_break(send_cycle)) begin
                    p = make_pair(next_idx);
                    next_idx++;
                    pts_ch.valid            <= 1'b1;
                    pts_ch.first_latitude   <= p.lat1;
                    pts_ch.first_longitude  <= p.lon1;
                    pts_ch.second_latitude  <= p.lat2;
                    pts_ch.second_longitude <= p.lon2;
                end else begin
                    pts_ch.valid <= 1'b0;
                end
            end
        end
    endtask

    // The receiver stalls at random; every handshake is checked in order.
    task automatic drain_distances();
        int cycle;
        cycle = 0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (dist_ch.valid && dist_ch.ready) scoreboard.check_distance(dist_ch.distance_cm);
            dist_ch.ready <= !take_break(cycle);
        end
    endtask

    initial begin
        pts_ch.valid            = 1'b0;
        pts_ch.first_latitude   = '0;
        pts_ch.first_longitude  = '0;
        pts_ch.second_latitude  = '0;
        pts_ch.second_longitude = '0;
        dist_ch.ready           = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_distances();
        join_none
        drive_points();
        // The last item has been taken; drain the pipeline.
        while (scoreboard.pending_cm.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.num_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // A run that hangs is ended here and counts as a failure.
    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
